### src/fba_pkg.sv
// Shared constants, operation codes and types for the frame bitmap allocator.
// No dependencies; compiled first.
`default_nettype none

package fba_pkg;

    // Word field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 27;
    localparam int FRAME_W = 15;

    // Bitmap geometry
    localparam int FBA_FRAME_COUNT = 32768;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
    localparam int BITS_PER_WORD   = 32;
    localparam int BIT_IDX_W       = 5;
    localparam logic [BITS_PER_WORD-1:0] ALL_USED = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd3;

    // Result of the free-bit search
    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] bit_idx;
    } fba_find_t;

endpackage

`default_nettype wire

### src/fba_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fba_pkg for field widths.
`default_nettype none

interface fba_req_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::OP_W-1:0]     operation;
    logic [fba_pkg::ADDR_W-1:0]   frame_address;

    modport source (output valid, output operation, output frame_address, input ready);
    modport sink   (input valid, input operation, input frame_address, output ready);
endinterface

interface fba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::FRAME_W-1:0]  frame_number;
    logic                         success;
    logic                         was_used;

    modport source (output valid, output frame_number, output success, output was_used,
                    input ready);
    modport sink   (input valid, input frame_number, input success, input was_used,
                    output ready);
endinterface

`default_nettype wire

### src/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: sequencer, bitmap RAM and search unit.
// Depends on fba_pkg, fba_if, fba_ram and fba_zero_find.
`default_nettype none

// Physical page frame allocator. One used/free bit per frame lives in a
// single-port-read bitmap RAM of ceil(FRAME_COUNT/32) words of 32 bits. After
// reset a clearing pass writes every word to zero, one word per cycle; no
// request word is taken during it. The block handles one request at a time.
// Mark-used and free read the frame's word and write it back; test only reads
// it. Such a request passes through the RMW and DONE states, and its response
// word is loaded into the output register once that register is free. A mark,
// free or test for a byte address past the last frame answers with success 0
// and leaves the bitmap alone. Allocate walks the words from word 0 upward,
// one word per cycle through the RAM read port and the search unit, until a
// word with a clear bit is found or the last word has been examined. The
// response sits in an output register, so the next request word is taken
// while the previous response still waits for the sink.

module frame_bitmap_allocator #(
    parameter int FRAME_COUNT = fba_pkg::FBA_FRAME_COUNT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fba_req_if.sink   req,
    fba_rsp_if.source rsp
);
    import fba_pkg::*;

    localparam int WORD_COUNT = (FRAME_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FC_W       = $clog2(FRAME_COUNT + 1) + 1;
    localparam int LAST_BITS  = FRAME_COUNT - BITS_PER_WORD * (WORD_COUNT - 1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);
    // bits of the last word beyond FRAME_COUNT always read as used
    localparam logic [BITS_PER_WORD-1:0] PAD_MASK =
        (LAST_BITS == BITS_PER_WORD) ? 32'h0 : ~((32'h1 << LAST_BITS) - 32'h1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RMW   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [WORD_AW-1:0]       word_reg, word_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [FRAME_W-1:0]       frame_reg, frame_next;

    // pending response, waiting for the output register
    logic [FRAME_W-1:0]       res_frame_reg, res_frame_next;
    logic                     res_ok_reg, res_ok_next;
    logic                     res_used_reg, res_used_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]       out_frame_reg, out_frame_next;
    logic                     out_ok_reg, out_ok_next;
    logic                     out_used_reg, out_used_next;

    // RAM ports
    logic                     ram_we;
    logic [WORD_AW-1:0]       ram_waddr;
    logic [BITS_PER_WORD-1:0] ram_wdata;
    logic [WORD_AW-1:0]       ram_raddr;
    logic [BITS_PER_WORD-1:0] ram_rdata;

    // search unit
    logic [BITS_PER_WORD-1:0] pad_sel;
    fba_find_t                find;

    // request decode
    logic [FRAME_W-1:0]       req_frame;
    logic [31:0]              req_frame_ext;
    logic                     req_in_range;
    logic                     req_take;

    logic [31:0]              scan_frame;
    logic [BITS_PER_WORD-1:0] bit_mask;
    logic                     out_load;

    fba_ram #(
        .WIDTH  (BITS_PER_WORD),
        .DEPTH  (WORD_COUNT),
        .ADDR_W (WORD_AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_zero_find u_find (
        .word     (ram_rdata),
        .pad_mask (pad_sel),
        .result   (find)
    );

    // address / page size is a plain shift
    assign req_frame     = req.frame_address[PAGE_SHIFT +: FRAME_W];
    assign req_frame_ext = 32'(req_frame);
    assign req_in_range  = (FC_W'(req_frame) < FC_W'(FRAME_COUNT));
    assign req.ready     = (state_reg == ST_IDLE);
    assign req_take      = req.valid && req.ready;

    assign scan_frame    = 32'({word_reg, find.bit_idx});
    assign bit_mask      = BITS_PER_WORD'(1) << frame_reg[BIT_IDX_W-1:0];
    assign pad_sel       = (word_reg == LAST_WORD) ? PAD_MASK : '0;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        op_next        = op_reg;
        frame_next     = frame_reg;
        res_frame_next = res_frame_reg;
        res_ok_next    = res_ok_reg;
        res_used_next  = res_used_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = word_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                word_next = word_reg + 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.operation == OP_ALLOC)
                begin
                    ram_raddr = '0;
                end
                else
                begin
                    ram_raddr = req_frame_ext[BIT_IDX_W +: WORD_AW];
                end
                if (req_take)
                begin
                    op_next    = req.operation;
                    frame_next = req_frame;
                    word_next  = ram_raddr;
                    if (req.operation == OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_in_range)
                    begin
                        state_next = ST_RMW;
                    end
                    else
                    begin
                        res_frame_next = req_frame;
                        res_ok_next    = 1'b0;
                        res_used_next  = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // rdata holds word_reg; fetch the next one meanwhile
                ram_raddr = word_reg + 1'b1;
                if (find.found)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata | (BITS_PER_WORD'(1) << find.bit_idx);
                    res_frame_next = scan_frame[FRAME_W-1:0];
                    res_ok_next    = 1'b1;
                    res_used_next  = 1'b0;
                    state_next     = ST_DONE;
                end
                else if (word_reg == LAST_WORD)
                begin
                    res_frame_next = '0;
                    res_ok_next    = 1'b0;
                    res_used_next  = 1'b0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            ST_RMW:
            begin
                ram_we         = (op_reg == OP_MARK) || (op_reg == OP_FREE);
                ram_wdata      = (op_reg == OP_MARK) ? (ram_rdata | bit_mask)
                                                     : (ram_rdata & ~bit_mask);
                res_frame_next = frame_reg;
                res_ok_next    = 1'b1;
                res_used_next  = ram_rdata[frame_reg[BIT_IDX_W-1:0]];
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_ok_next    = out_ok_reg;
        out_used_next  = out_used_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_frame_next = res_frame_reg;
            out_ok_next    = res_ok_reg;
            out_used_next  = res_used_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        frame_reg     <= frame_next;
        res_frame_reg <= res_frame_next;
        res_ok_reg    <= res_ok_next;
        res_used_reg  <= res_used_next;
        out_frame_reg <= out_frame_next;
        out_ok_reg    <= out_ok_next;
        out_used_reg  <= out_used_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.frame_number = out_frame_reg;
    assign rsp.success      = out_ok_reg;
    assign rsp.was_used     = out_used_reg;

endmodule

`default_nettype wire

### src/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/fba_zero_find.sv
// Search unit: lowest clear bit of one bitmap word, with padding bits forced used.
// Depends on fba_pkg.
`default_nettype none

module fba_zero_find (
    input  wire logic [fba_pkg::BITS_PER_WORD-1:0] word,
    input  wire logic [fba_pkg::BITS_PER_WORD-1:0] pad_mask,
    output fba_pkg::fba_find_t                     result
);
    import fba_pkg::*;

    logic [BITS_PER_WORD-1:0] masked;

    always_comb
    begin
        masked         = word | pad_mask;
        result.found   = (masked != ALL_USED);
        result.bit_idx = '0;
        // priority encode, lowest clear bit wins
        for (int i = BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                result.bit_idx = BIT_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire
